### rtl/dma_descriptor_ring_tracker_unit_macros.svh
// Assertion helpers used by the ring controller module.
// All of them sample on clk and are disabled while arst_n is low.
`ifndef DMA_DESCRIPTOR_RING_TRACKER_UNIT_MACROS_SVH
`define DMA_DESCRIPTOR_RING_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication.
`define DRT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/drt_pkg.sv
package drt_pkg;

	// Ring geometry.
	localparam int NUM_DESC = 128;
	localparam int IDX_W    = $clog2(NUM_DESC);

	// Fixed field widths of the command and result channels.
	localparam int SLOT_W   = 7;
	localparam int STAT_W   = 64;

	// Configuration port geometry: 64-bit registers at 8-byte spacing.
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = 5;

	// Register indexes.
	localparam logic [1:0] REG_CLOSING  = 2'd0;
	localparam logic [1:0] REG_EXC_MASK = 2'd1;
	localparam logic [1:0] REG_CMP_MASK = 2'd2;

	typedef enum logic [0:0] {
		CMD_POST   = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		RC_OK      = 2'd0,
		RC_CLOSING = 2'd1,
		RC_FULL    = 2'd2,
		RC_HW_ERR  = 2'd3
	} res_code_t;

	typedef enum logic [1:0] {
		OC_ERROR     = 2'd0,
		OC_COMPLETED = 2'd1,
		OC_CANCELED  = 2'd2
	} outcome_t;

	// Register contents handed to the ring controller.
	typedef struct packed {
		logic              closing;
		logic [STAT_W-1:0] exc_mask;
		logic [STAT_W-1:0] cmp_mask;
	} cfg_t;

	// Access request to the busy-bit store.
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

endpackage

### rtl/drt_cfg_regs.sv
module drt_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [drt_pkg::ADDR_W-1:0]   paddr,
	input  logic [drt_pkg::DATA_W-1:0]   pwdata,
	output logic [drt_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output drt_pkg::cfg_t                cfg
);

	logic       wr_fire;
	logic [1:0] reg_idx;
	logic                         closing_q;
	logic [drt_pkg::STAT_W-1:0]   exc_mask_q;
	logic [drt_pkg::STAT_W-1:0]   cmp_mask_q;

	// Registers sit on 8-byte boundaries; the low address bits are ignored.
	assign reg_idx = paddr[4:3];
	assign wr_fire = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes during the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closing_q  <= 1'b0;
			exc_mask_q <= '0;
			cmp_mask_q <= drt_pkg::STAT_W'(1);
		end else if (wr_fire) begin
			unique case (reg_idx)
				drt_pkg::REG_CLOSING:  closing_q  <= pwdata[0];
				drt_pkg::REG_EXC_MASK: exc_mask_q <= pwdata;
				drt_pkg::REG_CMP_MASK: cmp_mask_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		unique case (reg_idx)
			drt_pkg::REG_CLOSING:  prdata = drt_pkg::DATA_W'(closing_q);
			drt_pkg::REG_EXC_MASK: prdata = exc_mask_q;
			drt_pkg::REG_CMP_MASK: prdata = cmp_mask_q;
			default:               prdata = '0;
		endcase
	end

	assign cfg.closing  = closing_q;
	assign cfg.exc_mask = exc_mask_q;
	assign cfg.cmp_mask = cmp_mask_q;

endmodule

### rtl/drt_busy_store.sv
module drt_busy_store (
	input  logic              clk,
	input  logic              arst_n,
	input  drt_pkg::mem_req_t req,
	output logic              rd_data
);

	logic                         mem_q [drt_pkg::NUM_DESC];
	logic [drt_pkg::NUM_DESC-1:0] valid_q;
	logic                         rd_q;
	logic                         rd_valid_q;

	// Busy-bit memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem_q[req.rd_addr];
		end
	end

	// Per-entry valid bits so that never-written slots read as free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_q && rd_valid_q;

endmodule

### rtl/drt_ring_ctrl.sv
`include "dma_descriptor_ring_tracker_unit_macros.svh"

module drt_ring_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  drt_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [drt_pkg::SLOT_W-1:0]  slot,
	input  logic [drt_pkg::STAT_W-1:0]  status_word,
	input  logic [drt_pkg::SLOT_W-1:0]  read_pointer,
	input  logic                        post_ok,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  result_code,
	output logic [drt_pkg::SLOT_W-1:0]  assigned_slot,
	output logic [1:0]                  outcome,
	output logic [drt_pkg::SLOT_W-1:0]  ring_head,
	output logic [drt_pkg::SLOT_W-1:0]  used_count,
	output drt_pkg::mem_req_t           mem_req,
	input  logic                        mem_rd_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POST,
		ST_CLEAR,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

	localparam int W = drt_pkg::IDX_W;

	state_t                       state_q;
	logic [drt_pkg::SLOT_W-1:0]   slot_q;
	logic [drt_pkg::STAT_W-1:0]   status_q;
	logic [drt_pkg::SLOT_W-1:0]   rp_q;
	logic                         post_ok_q;
	logic [W-1:0]                 head_q;
	logic [W-1:0]                 count_q;
	drt_pkg::res_code_t           code_q;
	logic [W-1:0]                 given_q;
	drt_pkg::outcome_t            outc_q;

	logic                         in_fire;
	logic [W:0]                   slot_sum;
	logic [W-1:0]                 next_slot;
	logic [W-1:0]                 head_inc;
	logic                         ring_full;
	logic                         post_take;
	logic                         slot_in_range;
	logic                         walk_stop;
	logic                         out_free;
	drt_pkg::outcome_t            classify;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// Tail slot, (head + count) wrapped at the ring size.
	assign slot_sum  = {1'b0, head_q} + {1'b0, count_q};
	assign next_slot = (slot_sum >= (W+1)'(drt_pkg::NUM_DESC)) ?
		W'(slot_sum - (W+1)'(drt_pkg::NUM_DESC)) : slot_sum[W-1:0];
	assign head_inc  = (head_q == W'(drt_pkg::NUM_DESC - 1)) ? '0 : head_q + 1'b1;
	assign ring_full = (count_q >= W'(drt_pkg::NUM_DESC - 1));
	assign post_take = !cfg.closing && !ring_full && post_ok_q;
	assign slot_in_range = (32'(slot_q) < drt_pkg::NUM_DESC);

	// The walk ends at a busy head slot, an empty ring or the read pointer.
	assign walk_stop = mem_rd_data || (count_q == '0) || (32'(head_q) == 32'(rp_q));

	// Exception bits take priority over completion bits.
	always_comb begin
		if ((status_q & cfg.exc_mask) != '0) begin
			classify = drt_pkg::OC_ERROR;
		end else if ((status_q & cfg.cmp_mask) != '0) begin
			classify = drt_pkg::OC_COMPLETED;
		end else begin
			classify = drt_pkg::OC_CANCELED;
		end
	end

	// Busy-store accesses: set on a taken post, clear on finish, read during the walk.
	always_comb begin
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = next_slot;
		mem_req.wr_data = 1'b1;
		mem_req.rd_en   = (state_q == ST_READ);
		mem_req.rd_addr = head_q;
		if (state_q == ST_POST) begin
			mem_req.wr_en = post_take;
		end else if (state_q == ST_CLEAR) begin
			mem_req.wr_en   = slot_in_range;
			mem_req.wr_addr = W'(slot_q);
			mem_req.wr_data = 1'b0;
		end
	end

	// Sequencer with ring state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			head_q    <= '0;
			count_q   <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						slot_q    <= slot;
						status_q  <= status_word;
						rp_q      <= read_pointer;
						post_ok_q <= post_ok;
						state_q   <= (cmd == drt_pkg::CMD_FINISH) ? ST_CLEAR : ST_POST;
					end
				end
				ST_POST: begin
					outc_q  <= drt_pkg::OC_ERROR;
					if (cfg.closing) begin
						code_q  <= drt_pkg::RC_CLOSING;
						given_q <= '0;
					end else if (ring_full) begin
						code_q  <= drt_pkg::RC_FULL;
						given_q <= '0;
					end else if (!post_ok_q) begin
						code_q  <= drt_pkg::RC_HW_ERR;
						given_q <= '0;
					end else begin
						code_q  <= drt_pkg::RC_OK;
						given_q <= next_slot;
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					outc_q  <= classify;
					code_q  <= drt_pkg::RC_OK;
					given_q <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (walk_stop) begin
						state_q <= ST_DONE;
					end else begin
						count_q <= count_q - 1'b1;
						head_q  <= head_inc;
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						result_code   <= code_q;
						assigned_slot <= drt_pkg::SLOT_W'(given_q);
						outcome       <= outc_q;
						ring_head     <= drt_pkg::SLOT_W'(head_q);
						used_count    <= drt_pkg::SLOT_W'(count_q);
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`DRT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= W'(drt_pkg::NUM_DESC - 1), "ring count overflow")
	`DRT_ASSERT_NEXT(a_accept_locks, in_fire, in_stall, "input taken while a command is in flight")
	`DRT_ASSERT_NEXT(a_post_grows, state_q == ST_POST && post_take, count_q == $past(count_q) + 1'b1, "taken post did not grow the ring")
	`DRT_ASSERT_NEXT(a_walk_retires, state_q == ST_CHECK && !walk_stop, count_q == $past(count_q) - 1'b1 && state_q == ST_READ, "retire step lost")

endmodule

### rtl/dma_descriptor_ring_tracker_unit.sv
// Channel   Direction  Handshake            Payload
// command   in         in_valid / in_stall  cmd, slot, status_word, read_pointer, post_ok
// result    out        out_valid/ out_stall result_code, assigned_slot, outcome,
//                                           ring_head, used_count
// config    in         APB write/read       engine_closing, exception_mask, completed_mask
//
// A post runs through the POST and DONE states and loads its result into the output
// register in DONE once that register is free; the next transfer is taken back in IDLE.
// A finish runs through CLEAR, then a READ and CHECK pair for each slot checked, then DONE;
// each retire step reads the busy-bit memory and then checks its registered data.
// One command is in flight at a time; the next transfer is taken while the previous
// result still waits on out_stall.
// Reset clears the ring head, count and the per-slot valid bits at once; no sweep runs.
module dma_descriptor_ring_tracker_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [drt_pkg::ADDR_W-1:0]  paddr,
	input  logic [drt_pkg::DATA_W-1:0]  pwdata,
	output logic [drt_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [drt_pkg::SLOT_W-1:0]  slot,
	input  logic [drt_pkg::STAT_W-1:0]  status_word,
	input  logic [drt_pkg::SLOT_W-1:0]  read_pointer,
	input  logic                        post_ok,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  result_code,
	output logic [drt_pkg::SLOT_W-1:0]  assigned_slot,
	output logic [1:0]                  outcome,
	output logic [drt_pkg::SLOT_W-1:0]  ring_head,
	output logic [drt_pkg::SLOT_W-1:0]  used_count
);

	drt_pkg::cfg_t     cfg;
	drt_pkg::mem_req_t mem_req;
	logic              mem_rd_data;

	// Configuration registers.
	drt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Per-slot busy bits.
	drt_busy_store u_busy (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	// Command sequencer and ring state.
	drt_ring_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.slot          (slot),
		.status_word   (status_word),
		.read_pointer  (read_pointer),
		.post_ok       (post_ok),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_code   (result_code),
		.assigned_slot (assigned_slot),
		.outcome       (outcome),
		.ring_head     (ring_head),
		.used_count    (used_count),
		.mem_req       (mem_req),
		.mem_rd_data   (mem_rd_data)
	);

endmodule

### test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import drt_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN_WAIT  = 300;

	// One command as offered on the input channel.
	typedef struct {
		cmd_t              op;
		logic [SLOT_W-1:0] slot;
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] rp;
		logic              post_ok;
	} ring_cmd_t;

	// One result as seen on the output channel.
	typedef struct {
		res_code_t         code;
		logic [SLOT_W-1:0] given;
		outcome_t          oc;
		logic [SLOT_W-1:0] head;
		logic [SLOT_W-1:0] count;
	} ring_res_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                cmd = 1'b0;
	logic [SLOT_W-1:0]   slot = '0;
	logic [STAT_W-1:0]   status_word = '0;
	logic [SLOT_W-1:0]   read_pointer = '0;
	logic                post_ok = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          result_code;
	logic [SLOT_W-1:0]   assigned_slot;
	logic [1:0]          outcome;
	logic [SLOT_W-1:0]   ring_head;
	logic [SLOT_W-1:0]   used_count;

	// Shadow of the ring and the registers; the ring part advances at each input transfer.
	bit                  busy_model [NUM_DESC];
	logic [SLOT_W-1:0]   head_model;
	logic [SLOT_W-1:0]   count_model;
	logic                closing_reg;
	logic [STAT_W-1:0]   exc_reg;
	logic [STAT_W-1:0]   cmp_reg;

	ring_res_t           expected_results [$];
	int                  errors = 0;
	int                  cycle_count = 0;
	bit                  gaps_on = 1'b1;
	bit                  stalls_on = 1'b1;
	int                  hold_cycles = 0;
	int                  stall_left = 0;

	dma_descriptor_ring_tracker_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.slot         (slot),
		.status_word  (status_word),
		.read_pointer (read_pointer),
		.post_ok      (post_ok),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_code  (result_code),
		.assigned_slot(assigned_slot),
		.outcome      (outcome),
		.ring_head    (ring_head),
		.used_count   (used_count)
	);

	always #10 clk = ~clk;

	// Run guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** dma_descriptor_ring_tracker_unit: FAILED **");
			$finish;
		end
	end

	// Result side stall: a long hold when asked for, otherwise random bursts.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (stalls_on && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left = pick_idle_len() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Each result transfer is matched against the oldest prediction.
	always @(posedge clk) begin : result_check
		ring_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no prediction pending");
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("result_code", 7'(want.code), 7'(result_code));
				check_field("assigned_slot", want.given, assigned_slot);
				check_field("outcome", 7'(want.oc), 7'(outcome));
				check_field("ring_head", want.head, ring_head);
				check_field("used_count", want.count, used_count);
			end
		end
	end

	task automatic check_field(input string name, input logic [6:0] want,
			input logic [6:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Length of one idle stretch: mostly short, now and then long.
	function automatic int pick_idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 50);
	endfunction

	function automatic int pick_gap();
		if (!gaps_on || $urandom_range(0, 1) == 0)
			return 0;
		return pick_idle_len();
	endfunction

	// Status words: dense, single bit, zero or sparse.
	function automatic logic [STAT_W-1:0] rand_status();
		logic [STAT_W-1:0] a;
		logic [STAT_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return a;
			1: return 64'h1 << $urandom_range(0, STAT_W - 1);
			2: return '0;
			default: return a & b & {$urandom, $urandom};
		endcase
	endfunction

	// Next state and result of the ring for one command.
	function automatic ring_res_t ring_model_step(input ring_cmd_t c);
		ring_res_t         r;
		logic [SLOT_W-1:0] tail;
		int                n;
		r.code  = RC_OK;
		r.given = '0;
		r.oc    = OC_ERROR;
		if (c.op == CMD_POST) begin
			tail = head_model + count_model;
			if (closing_reg)
				r.code = RC_CLOSING;
			else if (count_model >= NUM_DESC - 1)
				r.code = RC_FULL;
			else if (!c.post_ok)
				r.code = RC_HW_ERR;
			else begin
				busy_model[tail] = 1'b1;
				count_model++;
				r.given = tail;
			end
		end else begin
			if ((c.status & exc_reg) != 0)
				r.oc = OC_ERROR;
			else if ((c.status & cmp_reg) != 0)
				r.oc = OC_COMPLETED;
			else
				r.oc = OC_CANCELED;
			busy_model[c.slot] = 1'b0;
			// Retire free slots in order until a busy one, the read pointer or empty.
			for (n = 0; n < NUM_DESC; n++) begin
				if (busy_model[head_model] || count_model == 0 || head_model == c.rp)
					break;
				count_model--;
				head_model++;
			end
		end
		r.head  = head_model;
		r.count = count_model;
		return r;
	endfunction

	function automatic ring_cmd_t make_post(input logic ok);
		ring_cmd_t c;
		c.op      = CMD_POST;
		c.slot    = SLOT_W'($urandom);
		c.status  = rand_status();
		c.rp      = SLOT_W'($urandom);
		c.post_ok = ok;
		return c;
	endfunction

	function automatic ring_cmd_t make_finish(input logic [SLOT_W-1:0] s,
			input logic [STAT_W-1:0] st, input logic [SLOT_W-1:0] rp);
		ring_cmd_t c;
		c.op      = CMD_FINISH;
		c.slot    = s;
		c.status  = st;
		c.rp      = rp;
		c.post_ok = 1'($urandom);
		return c;
	endfunction

	// Offer one command and predict its result once the transfer happens.
	task automatic send_item(input ring_cmd_t c);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c.op;
		slot         <= c.slot;
		status_word  <= c.status;
		read_pointer <= c.rp;
		post_ok      <= c.post_ok;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(ring_model_step(c));
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic wait_ring_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random post or finish; finishes mostly target live slots, and the post share keeps the fill level moving.
	task automatic send_random_item();
		int                pct;
		int                k;
		logic [SLOT_W-1:0] s;
		logic [SLOT_W-1:0] rp;
		pct = (count_model < 4) ? 75 : (count_model > 110) ? 35 : 55;
		if ($urandom_range(0, 99) < pct) begin
			send_item(make_post($urandom_range(0, 9) != 0));
		end else begin
			s = SLOT_W'($urandom);
			if (count_model != 0 && $urandom_range(0, 9) != 0) begin
				if (busy_model[head_model] && $urandom_range(0, 3) == 0)
					s = head_model;
				else
					for (k = 0; k < 8; k++) begin
						s = head_model + SLOT_W'($urandom_range(0, count_model - 1));
						if (busy_model[s])
							break;
					end
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: rp = head_model + count_model;
				6, 7: rp = head_model + SLOT_W'($urandom_range(0, count_model));
				default: rp = SLOT_W'($urandom);
			endcase
			send_item(make_finish(s, rand_status(), rp));
		end
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 3'b000};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] unused;
		apb_access(1'b1, idx, value, unused);
		case (idx)
			REG_CLOSING:  closing_reg = value[0];
			REG_EXC_MASK: exc_reg = value;
			REG_CMP_MASK: cmp_reg = value;
			default: ;
		endcase
	endtask

	task automatic check_register(input logic [1:0] idx, input logic [DATA_W-1:0] want);
		logic [DATA_W-1:0] got;
		apb_access(1'b0, idx, '0, got);
		if (idx == REG_CLOSING)
			got = {63'b0, got[0]};
		if (got !== want) begin
			$error("register %0d: expected %h, got %h", idx, want, got);
			errors++;
		end
	endtask

	task automatic run_random_items(input int n);
		repeat (n) send_random_item();
		wait_ring_idle();
	endtask

	// Reset values, then write and read back every register.
	task automatic test_register_access();
		check_register(REG_CLOSING, 64'd0);
		check_register(REG_EXC_MASK, 64'd0);
		check_register(REG_CMP_MASK, 64'd1);
		set_config(REG_CLOSING, 64'd1);
		set_config(REG_EXC_MASK, 64'hA5A5_0F0F_FFFF_0001);
		set_config(REG_CMP_MASK, 64'h5A5A_F0F0_0000_FFFE);
		check_register(REG_CLOSING, 64'd1);
		check_register(REG_EXC_MASK, 64'hA5A5_0F0F_FFFF_0001);
		check_register(REG_CMP_MASK, 64'h5A5A_F0F0_0000_FFFE);
		set_config(REG_CLOSING, 64'd0);
		set_config(REG_EXC_MASK, 64'd0);
		set_config(REG_CMP_MASK, 64'd1);
	endtask

	// Hand-picked posts and finishes covering the hardware and closing refusals and each retirement stop.
	task automatic test_directed_cases();
		send_item(make_post(1'b0));
		repeat (3) send_item(make_post(1'b1));
		// Finishing a slot behind a busy head retires nothing.
		send_item(make_finish(7'd1, 64'h1, 7'd127));
		// Head free but equal to the read pointer: retirement holds.
		send_item(make_finish(7'd0, 64'h0, 7'd0));
		// Slot already free; retirement runs up to the busy slot.
		send_item(make_finish(7'd0, '1, 7'd3));
		send_item(make_finish(7'd127, 64'h8000_0000_0000_0000, 7'd127));
		wait_ring_idle();
		// Exception mask wins over the completed mask.
		set_config(REG_EXC_MASK, 64'h8000_0000_0000_0000);
		send_item(make_finish(7'd2, 64'h8000_0000_0000_0001, 7'd127));
		send_item(make_finish(7'd3, 64'h1, 7'd0));
		send_item(make_post(1'b1));
		wait_ring_idle();
		set_config(REG_CLOSING, 64'd1);
		send_item(make_post(1'b1));
		send_item(make_post(1'b0));
		send_item(make_finish(7'd3, 64'h0, 7'd4));
		wait_ring_idle();
		set_config(REG_CLOSING, 64'd0);
		set_config(REG_EXC_MASK, 64'd0);
	endtask

	// Fill the ring, hit both refusals, then drain it out of order.
	task automatic test_full_ring();
		logic [SLOT_W-1:0] order [$];
		logic [SLOT_W-1:0] t;
		int                i;
		int                j;
		while (count_model < NUM_DESC - 1)
			send_item(make_post(1'b1));
		send_item(make_post(1'b1));
		send_item(make_post(1'b0));
		wait_ring_idle();
		// Closing is reported ahead of a full ring.
		set_config(REG_CLOSING, 64'd1);
		send_item(make_post(1'b1));
		wait_ring_idle();
		set_config(REG_CLOSING, 64'd0);
		for (i = 1; i < count_model; i++)
			order.push_back(head_model + SLOT_W'(i));
		for (i = order.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (order[i])
			send_item(make_finish(order[i], rand_status(), SLOT_W'($urandom)));
		// Freeing the head now retires the whole ring in one walk.
		send_item(make_finish(head_model, rand_status(), head_model + count_model));
		wait_ring_idle();
	endtask

	// Long result hold while commands keep coming, then a full drain pause.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_cycles = LONG_HOLD;
		repeat (30) send_random_item();
		wait_ring_idle();
		repeat (20) send_random_item();
		wait_ring_idle();
		gaps_on = 1'b1;
	endtask

	// Random traffic under a sequence of register settings, extremes included.
	task automatic test_config_sweep();
		run_random_items(130);
		set_config(REG_EXC_MASK, 64'h1 << $urandom_range(0, STAT_W - 1));
		set_config(REG_CMP_MASK, {$urandom, $urandom} & {$urandom, $urandom});
		run_random_items(350);
		set_config(REG_EXC_MASK, '1);
		set_config(REG_CMP_MASK, '1);
		run_random_items(150);
		set_config(REG_EXC_MASK, '0);
		set_config(REG_CMP_MASK, '0);
		run_random_items(150);
		// A stretch with no idling on either side.
		set_config(REG_CMP_MASK, '1);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		run_random_items(150);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		set_config(REG_CLOSING, 64'd1);
		run_random_items(50);
		set_config(REG_CLOSING, 64'd0);
		set_config(REG_EXC_MASK, {$urandom, $urandom} & {$urandom, $urandom} &
			{$urandom, $urandom});
		set_config(REG_CMP_MASK, {$urandom, $urandom});
		run_random_items(250);
	endtask

	initial begin
		foreach (busy_model[i])
			busy_model[i] = 1'b0;
		head_model  = '0;
		count_model = '0;
		closing_reg = 1'b0;
		exc_reg     = '0;
		cmp_reg     = 64'd1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_register_access();
		test_directed_cases();
		test_full_ring();
		test_backpressure();
		test_config_sweep();
		wait_ring_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("** dma_descriptor_ring_tracker_unit: PASSED **");
		else
			$display("** dma_descriptor_ring_tracker_unit: FAILED **");
		$finish;
	end

endmodule
